### hw/rtl/tso_pkg.sv
// tso_pkg: shared types and constants of the tile scan order generator
// used by tso_div, tso_walk and tile_scan_order_generator; no dependencies

package tso_pkg;

  // pixel dimension width (target and tile sizes)
  localparam int unsigned DIM_W = 13;
  // tile coordinate and pixel origin width
  localparam int unsigned COORD_W = 12;
  // position in the visiting order
  localparam int unsigned INDEX_W = 24;
  // largest target size taken into account
  localparam logic [DIM_W-1:0] MAX_TARGET = 13'd4096;
  // number of quotient bits the divider produces, one per cycle
  localparam int unsigned DIV_STEPS = DIM_W;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TILE_WIDTH    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TILE_HEIGHT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_X_FROM_RIGHT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_FROM_BOTTOM = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_MAJOR     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SCAN_OPTIONS  = 3'd7;

  // scan options latched at restart
  typedef struct packed {
    logic xr;    // start at right column
    logic yb;    // start at bottom row
    logic rm;    // row-major walk
    logic serp;  // serpentine lines
    logic sep;   // partial tiles scanned separately
  } tso_opts_t;

  // sequencer commands to the scan walker
  typedef struct packed {
    logic restart;     // clear counts, position and index
    logic set_cols;    // load column count from the divider
    logic set_rows;    // load row count from the divider
    logic begin_scan;  // place the walker on the first tile
    logic step;        // a tile has been emitted, advance
  } tso_walk_ctrl_t;

  // current tile as seen by the sequencer
  typedef struct packed {
    logic               active;
    logic [INDEX_W-1:0] index;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               last;
  } tso_tile_t;

endpackage

### hw/rtl/tso_div.sv
// tso_div: shared restoring divider, one quotient bit per cycle
// depends on tso_pkg for widths

module tso_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [tso_pkg::DIM_W-1:0] dividend,
  input  logic [tso_pkg::DIM_W-1:0] divisor,
  output logic                     done,
  output logic [tso_pkg::DIM_W-1:0] quotient,
  output logic                     rem_nz
);

  logic [tso_pkg::DIM_W-1:0] quo_r;
  logic [tso_pkg::DIM_W-1:0] rem_r;
  logic [tso_pkg::DIM_W-1:0] dvs_r;
  logic [3:0]                cnt_r;
  logic                      run_r;
  logic                      done_r;

  logic [tso_pkg::DIM_W:0]   trial;
  logic                      fits;
  logic [tso_pkg::DIM_W:0]   diff;
  logic [tso_pkg::DIM_W-1:0] rem_nxt;
  logic [tso_pkg::DIM_W-1:0] quo_nxt;

  // shift one dividend bit into the partial remainder, subtract if it fits
  always_comb begin
    trial   = {rem_r, quo_r[tso_pkg::DIM_W-1]};
    fits    = trial >= {1'b0, dvs_r};
    diff    = trial - {1'b0, dvs_r};
    rem_nxt = fits ? diff[tso_pkg::DIM_W-1:0] : trial[tso_pkg::DIM_W-1:0];
    quo_nxt = {quo_r[tso_pkg::DIM_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 4'd0;
    end else if (start) begin
      run_r  <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= 4'(tso_pkg::DIV_STEPS);
      quo_r  <= dividend;
      rem_r  <= '0;
      dvs_r  <= divisor;
    end else if (run_r) begin
      quo_r  <= quo_nxt;
      rem_r  <= rem_nxt;
      cnt_r  <= cnt_r - 4'd1;
      if (cnt_r == 4'd1) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;
  assign rem_nz   = |rem_r;

endmodule

### hw/rtl/tso_walk.sv
// tso_walk: tile counts, scan position and visiting order index
// depends on tso_pkg for the option, command and tile structs

module tso_walk (
  input  logic                      clk,
  input  logic                      rst_n,
  input  tso_pkg::tso_walk_ctrl_t   ctrl,
  input  tso_pkg::tso_opts_t        opts,
  input  logic [tso_pkg::DIM_W-1:0] div_quo,
  input  logic                      div_rem_nz,
  output tso_pkg::tso_tile_t        tile
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_MAIN,
    PH_PCOL,
    PH_PROW
  } phase_t;

  typedef struct packed {
    phase_t                      phase;
    logic [tso_pkg::COORD_W-1:0] col;
    logic [tso_pkg::COORD_W-1:0] row;
  } start_t;

  logic [tso_pkg::DIM_W-1:0]   full_cols_r;
  logic [tso_pkg::DIM_W-1:0]   full_rows_r;
  logic                        extra_col_r;
  logic                        extra_row_r;
  logic [tso_pkg::COORD_W-1:0] cur_col_r;
  logic [tso_pkg::COORD_W-1:0] cur_row_r;
  logic                        srev_r;
  logic [tso_pkg::DIM_W-1:0]   line_pos_r;
  logic [tso_pkg::INDEX_W-1:0] index_r;
  phase_t                      phase_r;

  logic [tso_pkg::DIM_W-1:0]   px, py, tx, ty;
  logic [tso_pkg::DIM_W-1:0]   px_m1, py_m1, tx_m1, ty_m1, fc_m1;
  logic [tso_pkg::DIM_W:0]     line_inc;
  logic [tso_pkg::DIM_W-1:0]   len;

  start_t                      begin_sp;
  phase_t                      phase_nxt;
  logic [tso_pkg::COORD_W-1:0] col_nxt;
  logic [tso_pkg::COORD_W-1:0] row_nxt;
  logic                        srev_nxt;
  logic [tso_pkg::DIM_W-1:0]   line_pos_nxt;

  // grid sizes: primary grid holds partial tiles unless they go separately
  always_comb begin
    px    = full_cols_r + {12'd0, extra_col_r & ~opts.sep};
    py    = full_rows_r + {12'd0, extra_row_r & ~opts.sep};
    tx    = full_cols_r + {12'd0, extra_col_r};
    ty    = full_rows_r + {12'd0, extra_row_r};
    px_m1 = px - 13'd1;
    py_m1 = py - 13'd1;
    tx_m1 = tx - 13'd1;
    ty_m1 = ty - 13'd1;
    fc_m1 = full_cols_r - 13'd1;
  end

  // first tile of the earliest non-empty region among the ones allowed
  function automatic start_t start_phase(input logic try_main, input logic try_pcol,
                                         input logic try_prow);
    start_t sp;
    sp.phase = PH_IDLE;
    sp.col   = cur_col_r;
    sp.row   = cur_row_r;
    if (try_main && px != '0 && py != '0) begin
      sp.phase = PH_MAIN;
      sp.col   = opts.xr ? px_m1[tso_pkg::COORD_W-1:0] : '0;
      sp.row   = opts.yb ? py_m1[tso_pkg::COORD_W-1:0] : '0;
    end else if (try_pcol && opts.sep && extra_col_r && ty != '0) begin
      sp.phase = PH_PCOL;
      sp.col   = tx_m1[tso_pkg::COORD_W-1:0];
      sp.row   = opts.yb ? ty_m1[tso_pkg::COORD_W-1:0] : '0;
    end else if (try_prow && opts.sep && extra_row_r && ty != '0 &&
                 full_cols_r != '0) begin
      // partial row leaves out the corner tile
      sp.phase = PH_PROW;
      sp.row   = ty_m1[tso_pkg::COORD_W-1:0];
      sp.col   = opts.xr ? fc_m1[tso_pkg::COORD_W-1:0] : '0;
    end
    return sp;
  endfunction

  always_comb begin
    begin_sp = start_phase(1'b1, 1'b1, 1'b1);
  end

  // next position after the current tile
  always_comb begin
    start_t sp;
    sp           = start_phase(1'b0, 1'b1, 1'b1);
    phase_nxt    = phase_r;
    col_nxt      = cur_col_r;
    row_nxt      = cur_row_r;
    srev_nxt     = srev_r;
    line_pos_nxt = line_pos_r;
    line_inc     = {1'b0, line_pos_r} + 14'd1;
    len          = opts.rm ? px : py;
    case (phase_r)
      PH_MAIN: begin
        if (line_inc < {1'b0, len}) begin
          line_pos_nxt = line_inc[tso_pkg::DIM_W-1:0];
          if (opts.rm) begin
            col_nxt = (opts.xr ^ srev_r) ? cur_col_r - 12'd1 : cur_col_r + 12'd1;
          end else begin
            row_nxt = (opts.yb ^ srev_r) ? cur_row_r - 12'd1 : cur_row_r + 12'd1;
          end
        end else if (opts.rm) begin
          if (cur_row_r == (opts.yb ? '0 : py_m1[tso_pkg::COORD_W-1:0])) begin
            phase_nxt    = sp.phase;
            col_nxt      = sp.col;
            row_nxt      = sp.row;
            srev_nxt     = 1'b0;
            line_pos_nxt = '0;
          end else begin
            row_nxt      = opts.yb ? cur_row_r - 12'd1 : cur_row_r + 12'd1;
            line_pos_nxt = '0;
            if (opts.serp) begin
              srev_nxt = ~srev_r;
            end else begin
              col_nxt = opts.xr ? px_m1[tso_pkg::COORD_W-1:0] : '0;
            end
          end
        end else begin
          if (cur_col_r == (opts.xr ? '0 : px_m1[tso_pkg::COORD_W-1:0])) begin
            phase_nxt    = sp.phase;
            col_nxt      = sp.col;
            row_nxt      = sp.row;
            srev_nxt     = 1'b0;
            line_pos_nxt = '0;
          end else begin
            col_nxt      = opts.xr ? cur_col_r - 12'd1 : cur_col_r + 12'd1;
            line_pos_nxt = '0;
            if (opts.serp) begin
              srev_nxt = ~srev_r;
            end else begin
              row_nxt = opts.yb ? py_m1[tso_pkg::COORD_W-1:0] : '0;
            end
          end
        end
      end
      PH_PCOL: begin
        if (line_inc < {1'b0, ty}) begin
          line_pos_nxt = line_inc[tso_pkg::DIM_W-1:0];
          row_nxt      = opts.yb ? cur_row_r - 12'd1 : cur_row_r + 12'd1;
        end else begin
          sp           = start_phase(1'b0, 1'b0, 1'b1);
          phase_nxt    = sp.phase;
          col_nxt      = sp.col;
          row_nxt      = sp.row;
          srev_nxt     = 1'b0;
          line_pos_nxt = '0;
        end
      end
      PH_PROW: begin
        if (line_inc < {1'b0, full_cols_r}) begin
          line_pos_nxt = line_inc[tso_pkg::DIM_W-1:0];
          col_nxt      = opts.xr ? cur_col_r - 12'd1 : cur_col_r + 12'd1;
        end else begin
          phase_nxt    = PH_IDLE;
          srev_nxt     = 1'b0;
          line_pos_nxt = '0;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.restart) begin
      full_cols_r <= '0;
      full_rows_r <= '0;
      extra_col_r <= 1'b0;
      extra_row_r <= 1'b0;
      cur_col_r   <= '0;
      cur_row_r   <= '0;
      srev_r      <= 1'b0;
      line_pos_r  <= '0;
      index_r     <= '0;
      phase_r     <= PH_IDLE;
    end else if (ctrl.set_cols) begin
      full_cols_r <= div_quo;
      extra_col_r <= div_rem_nz;
    end else if (ctrl.set_rows) begin
      full_rows_r <= div_quo;
      extra_row_r <= div_rem_nz;
    end else if (ctrl.begin_scan) begin
      phase_r    <= begin_sp.phase;
      cur_col_r  <= begin_sp.col;
      cur_row_r  <= begin_sp.row;
      srev_r     <= 1'b0;
      line_pos_r <= '0;
    end else if (ctrl.step && phase_r != PH_IDLE) begin
      phase_r    <= phase_nxt;
      cur_col_r  <= col_nxt;
      cur_row_r  <= row_nxt;
      srev_r     <= srev_nxt;
      line_pos_r <= line_pos_nxt;
      index_r    <= index_r + 24'd1;
    end
  end

  assign tile.active = phase_r != PH_IDLE;
  assign tile.index  = index_r;
  assign tile.col    = cur_col_r;
  assign tile.row    = cur_row_r;
  assign tile.last   = phase_nxt == PH_IDLE;

endmodule

### hw/rtl/tile_scan_order_generator.sv
// tile_scan_order_generator: top level, configuration registers, sequencer, result register
// depends on tso_pkg, tso_div and tso_walk
//
// Walks the render tiles of a target in a configurable order and gives one tile per
// input transfer: its column and row, pixel origin, position in the order and a mark
// on the final tile. An input with restart set latches the tile sizes and the scan
// options, divides the clamped target width and height by the tile size on one shared
// bit-serial divider (width first, then height) and gives the first tile through the
// states S_DIV_X, S_DIV_Y, S_BEGIN and S_EMIT. An input without restart, or a restart
// with a zero tile size, goes straight to S_EMIT, where its result is registered
// once the output register is free; in_ready comes back when the state is S_IDLE.
// The block takes one item at a time and holds in_ready low until that item's result
// is loaded into the output register, so a new item may be taken while the previous
// result still waits for out_ready. A zero tile size, a finished sequence or no restart
// yet give a result with valid_res low and all other fields zero. Configuration writes
// only count at the next restart and must be made while the block is idle.

module tile_scan_order_generator (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration
  input  logic                                cfg_we,
  input  logic [tso_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tso_pkg::DIM_W-1:0]           cfg_data,
  // input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_restart,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_valid_res,
  output logic [tso_pkg::INDEX_W-1:0]         out_tile_index,
  output logic [tso_pkg::COORD_W-1:0]         out_tile_col,
  output logic [tso_pkg::COORD_W-1:0]         out_tile_row,
  output logic [tso_pkg::COORD_W-1:0]         out_pixel_x,
  output logic [tso_pkg::COORD_W-1:0]         out_pixel_y,
  output logic                                out_last
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV_X,
    S_DIV_Y,
    S_BEGIN,
    S_EMIT
  } state_t;

  // configuration registers
  logic [tso_pkg::DIM_W-1:0] target_width_r;
  logic [tso_pkg::DIM_W-1:0] target_height_r;
  logic [tso_pkg::DIM_W-1:0] tile_width_r;
  logic [tso_pkg::DIM_W-1:0] tile_height_r;
  logic                      x_from_right_r;
  logic                      y_from_bottom_r;
  logic                      row_major_r;
  logic [1:0]                scan_options_r;

  // settings latched at restart; only the low tile size bits reach the pixel origin
  tso_pkg::tso_opts_t          opts_r;
  logic [tso_pkg::COORD_W-1:0] lat_tw_r;
  logic [tso_pkg::COORD_W-1:0] lat_th_r;

  state_t                      state_r;

  // result register
  logic                        out_valid_r;
  logic                        out_valid_res_r;
  logic [tso_pkg::INDEX_W-1:0] out_tile_index_r;
  logic [tso_pkg::COORD_W-1:0] out_tile_col_r;
  logic [tso_pkg::COORD_W-1:0] out_tile_row_r;
  logic [tso_pkg::COORD_W-1:0] out_pixel_x_r;
  logic [tso_pkg::COORD_W-1:0] out_pixel_y_r;
  logic                        out_last_r;

  logic                        in_xfer;
  logic                        out_free;
  logic                        load_res;
  logic                        tile_zero;
  logic [tso_pkg::DIM_W-1:0]   tw_clamp;
  logic [tso_pkg::DIM_W-1:0]   th_clamp;

  logic                        div_start;
  logic [tso_pkg::DIM_W-1:0]   div_dividend;
  logic [tso_pkg::DIM_W-1:0]   div_divisor;
  logic                        div_done;
  logic [tso_pkg::DIM_W-1:0]   div_quo;
  logic                        div_rem_nz;

  tso_pkg::tso_walk_ctrl_t     walk_ctrl;
  tso_pkg::tso_tile_t          tile;

  logic [2*tso_pkg::COORD_W-1:0] prod_x;
  logic [2*tso_pkg::COORD_W-1:0] prod_y;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_width_r  <= '0;
      target_height_r <= '0;
      tile_width_r    <= 13'd256;
      tile_height_r   <= 13'd256;
      x_from_right_r  <= 1'b0;
      y_from_bottom_r <= 1'b0;
      row_major_r     <= 1'b1;
      scan_options_r  <= 2'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        tso_pkg::CFG_TARGET_WIDTH:  target_width_r  <= cfg_data;
        tso_pkg::CFG_TARGET_HEIGHT: target_height_r <= cfg_data;
        tso_pkg::CFG_TILE_WIDTH:    tile_width_r    <= cfg_data;
        tso_pkg::CFG_TILE_HEIGHT:   tile_height_r   <= cfg_data;
        tso_pkg::CFG_X_FROM_RIGHT:  x_from_right_r  <= cfg_data[0];
        tso_pkg::CFG_Y_FROM_BOTTOM: y_from_bottom_r <= cfg_data[0];
        tso_pkg::CFG_ROW_MAJOR:     row_major_r     <= cfg_data[0];
        tso_pkg::CFG_SCAN_OPTIONS:  scan_options_r  <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  assign in_ready  = state_r == S_IDLE;
  assign in_xfer   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign load_res  = state_r == S_EMIT && out_free;
  assign tile_zero = tile_width_r == '0 || tile_height_r == '0;

  // target sizes beyond the supported maximum are clamped
  assign tw_clamp = (target_width_r > tso_pkg::MAX_TARGET) ? tso_pkg::MAX_TARGET
                                                           : target_width_r;
  assign th_clamp = (target_height_r > tso_pkg::MAX_TARGET) ? tso_pkg::MAX_TARGET
                                                            : target_height_r;

  // one divider: width division starts on the restart transfer, height after it
  always_comb begin
    div_start    = (in_xfer && in_restart && !tile_zero) ||
                   (state_r == S_DIV_X && div_done);
    div_dividend = (state_r == S_IDLE) ? tw_clamp : th_clamp;
    div_divisor  = (state_r == S_IDLE) ? tile_width_r : tile_height_r;
  end

  always_comb begin
    walk_ctrl.restart    = in_xfer && in_restart;
    walk_ctrl.set_cols   = state_r == S_DIV_X && div_done;
    walk_ctrl.set_rows   = state_r == S_DIV_Y && div_done;
    walk_ctrl.begin_scan = state_r == S_BEGIN;
    walk_ctrl.step       = state_r == S_EMIT && out_free;
  end

  tso_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo),
    .rem_nz   (div_rem_nz)
  );

  tso_walk u_walk (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (walk_ctrl),
    .opts       (opts_r),
    .div_quo    (div_quo),
    .div_rem_nz (div_rem_nz),
    .tile       (tile)
  );

  // pixel origin, low bits only
  assign prod_x = {12'd0, tile.col} * {12'd0, lat_tw_r};
  assign prod_y = {12'd0, tile.row} * {12'd0, lat_th_r};

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      opts_r      <= '{xr: 1'b0, yb: 1'b0, rm: 1'b1, serp: 1'b0, sep: 1'b0};
      lat_tw_r    <= '0;
      lat_th_r    <= '0;
    end else begin
      // a new result may replace the one leaving in the same cycle
      if (load_res) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            if (in_restart) begin
              opts_r.xr   <= x_from_right_r;
              opts_r.yb   <= y_from_bottom_r;
              opts_r.rm   <= row_major_r;
              opts_r.serp <= scan_options_r[0];
              opts_r.sep  <= scan_options_r[1];
              lat_tw_r    <= tile_width_r[tso_pkg::COORD_W-1:0];
              lat_th_r    <= tile_height_r[tso_pkg::COORD_W-1:0];
              state_r     <= tile_zero ? S_EMIT : S_DIV_X;
            end else begin
              state_r <= S_EMIT;
            end
          end
        end
        S_DIV_X: begin
          if (div_done) begin
            state_r <= S_DIV_Y;
          end
        end
        S_DIV_Y: begin
          if (div_done) begin
            state_r <= S_BEGIN;
          end
        end
        S_BEGIN: begin
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_res_r  <= tile.active;
            out_tile_index_r <= tile.active ? tile.index : '0;
            out_tile_col_r   <= tile.active ? tile.col : '0;
            out_tile_row_r   <= tile.active ? tile.row : '0;
            out_pixel_x_r    <= tile.active ? prod_x[tso_pkg::COORD_W-1:0] : '0;
            out_pixel_y_r    <= tile.active ? prod_y[tso_pkg::COORD_W-1:0] : '0;
            out_last_r       <= tile.active && tile.last;
            state_r          <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_valid_res  = out_valid_res_r;
  assign out_tile_index = out_tile_index_r;
  assign out_tile_col   = out_tile_col_r;
  assign out_tile_row   = out_tile_row_r;
  assign out_pixel_x    = out_pixel_x_r;
  assign out_pixel_y    = out_pixel_y_r;
  assign out_last       = out_last_r;

endmodule
